@@ rtl/packbits_row_decoder_assert.svh @@
// Assertion macros shared by the pbd_front and pbd_fifo modules.
`ifndef PACKBITS_ROW_DECODER_ASSERT_SVH
`define PACKBITS_ROW_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PBD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBD_ASSERT(name, prop, msg)
`define PBD_ASSERT_IMP(name, ante, cons, msg)
`endif
`endif

@@ rtl/pbd_pkg.sv @@
// Types and constants of the PackBits row decoder.
package pbd_pkg;

  localparam logic [7:0]  NoopHeader = 8'h80;
  localparam logic [16:0] CountMax   = 17'h1FFFF;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusTruncRun = 2'd1;
  localparam logic [1:0] StatusMismatch = 2'd2;

  typedef struct packed {
    logic [1:0] row_status;
    logic       row_done;
    logic [7:0] run_count;
    logic [7:0] run_value;
  } run_desc_t;

endpackage

@@ rtl/packbits_row_decoder.sv @@
// PackBits row decoder top level: parser, descriptor queue and output register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | tdata: code_byte; tlast: row_end
//  m_axis   | m_axis_tvalid/m_axis_tready | tdata: run_value, run_count;
//           |                             | tlast: row_done; tuser: row_status
//  cfg      | cfg_valid_i/cfg_ready_o     | cfg_data_i: row_width
//
// One compressed byte is taken every cycle while the descriptor queue has room.
// A result is held first in the queue, then in the output register, before it
// leaves. A stalled output fills the FifoDepth-entry queue, then s_axis_tready
// drops. Reset clears the parser state, queue and row_width.
module packbits_row_decoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] run_value, [15:8] run_count
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // [1:0] row_status
);

  logic               in_fire, push, full, nonempty, pop;
  pbd_pkg::run_desc_t push_desc, head_desc, out_desc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  pbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .code_byte_i (s_axis_tdata),
    .row_end_i   (s_axis_tlast),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  pbd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_data_o  (head_desc)
  );

  pbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (nonempty),
    .q_data_i     (head_desc),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_desc)
  );

  assign m_axis_tdata = {out_desc.run_count, out_desc.run_value};
  assign m_axis_tlast = out_desc.row_done;
  assign m_axis_tuser = out_desc.row_status;

endmodule

@@ rtl/pbd_front.sv @@
// Front end: parses header / literal / repeat bytes and builds run descriptors.
module pbd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_fire_i,
  input  logic [7:0]          code_byte_i,
  input  logic                row_end_i,
  output logic                push_o,
  output pbd_pkg::run_desc_t  desc_o
);

  `include "packbits_row_decoder_assert.svh"

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhLiteral = 2'd1;
  localparam logic [1:0] PhRepeat  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  lit_left_q, lit_left_d;
  logic [7:0]  rep_cnt_q, rep_cnt_d;
  logic [16:0] count_q, count_d;
  logic [15:0] row_width_q;

  logic        emit;
  logic [7:0]  add;
  logic [17:0] sum;
  logic [1:0]  phase_n;
  logic [16:0] count_n;

  always_comb begin
    phase_n    = phase_q;
    lit_left_d = lit_left_q;
    rep_cnt_d  = rep_cnt_q;
    emit       = 1'b0;
    add        = 8'd0;
    desc_o.run_value  = 8'd0;
    desc_o.run_count  = 8'd0;
    desc_o.row_done   = row_end_i;
    desc_o.row_status = pbd_pkg::StatusOk;

    case (phase_q)
      PhHeader: begin
        if ((count_q < {1'b0, row_width_q}) && (code_byte_i != pbd_pkg::NoopHeader)) begin
          if (!code_byte_i[7]) begin
            lit_left_d = code_byte_i + 8'd1;
            phase_n    = PhLiteral;
          end else begin
            rep_cnt_d = 8'(9'd257 - {1'b0, code_byte_i});
            phase_n   = PhRepeat;
          end
        end
      end
      PhLiteral: begin
        emit             = 1'b1;
        desc_o.run_value = code_byte_i;
        desc_o.run_count = 8'd1;
        add              = 8'd1;
        lit_left_d       = lit_left_q - 8'd1;
        if (lit_left_d == 8'd0) phase_n = PhHeader;
      end
      PhRepeat: begin
        emit             = 1'b1;
        desc_o.run_value = code_byte_i;
        desc_o.run_count = rep_cnt_q;
        add              = rep_cnt_q;
        rep_cnt_d        = 8'd0;
        phase_n          = PhHeader;
      end
      default: phase_n = PhHeader;
    endcase

    sum     = {1'b0, count_q} + {10'd0, add};
    count_n = (sum > {1'b0, pbd_pkg::CountMax}) ? pbd_pkg::CountMax : sum[16:0];
    phase_d = phase_n;
    count_d = count_n;

    if (row_end_i) begin
      if (phase_n != PhHeader) begin
        desc_o.row_status = pbd_pkg::StatusTruncRun;
      end else if (count_n != {1'b0, row_width_q}) begin
        desc_o.row_status = pbd_pkg::StatusMismatch;
      end
      phase_d    = PhHeader;
      lit_left_d = 8'd0;
      rep_cnt_d  = 8'd0;
      count_d    = 17'd0;
    end
  end

  assign push_o = in_fire_i && (emit || row_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      lit_left_q  <= 8'd0;
      rep_cnt_q   <= 8'd0;
      count_q     <= 17'd0;
      row_width_q <= 16'd0;
    end else begin
      if (cfg_we_i) row_width_q <= cfg_data_i;
      if (in_fire_i) begin
        phase_q    <= phase_d;
        lit_left_q <= lit_left_d;
        rep_cnt_q  <= rep_cnt_d;
        count_q    <= count_d;
      end
    end
  end

  `PBD_ASSERT(a_lit_nonzero, (phase_q == PhLiteral) |-> (lit_left_q != 8'd0), "literal run with nothing left")
  `PBD_ASSERT_IMP(a_row_end_clears, in_fire_i && row_end_i, (phase_q == PhHeader) && (count_q == 17'd0), "row end did not clear decoder")
  `PBD_ASSERT(a_rep_range, (phase_q == PhRepeat) |-> ((rep_cnt_q >= 8'd2) && (rep_cnt_q <= 8'd128)), "repeat count out of range")

endmodule

@@ rtl/pbd_fifo.sv @@
// Short descriptor queue between the parser and the output stage.
module pbd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pbd_pkg::run_desc_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                nonempty_o,
  output pbd_pkg::run_desc_t  pop_data_o
);

  `include "packbits_row_decoder_assert.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pbd_pkg::run_desc_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  `PBD_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count beyond depth")
  `PBD_ASSERT(a_no_overflow, push_i |-> !full_o, "request pushed into full queue")
  `PBD_ASSERT_IMP(a_drain, (cnt_q == CntW'(1)) && do_pop && !do_push, !nonempty_o && (wr_ptr_q == rd_ptr_q), "queue not empty after last pop")

endmodule

@@ rtl/pbd_back.sv @@
// Back end: output register that hands descriptors to the result stream.
module pbd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_nonempty_i,
  input  pbd_pkg::run_desc_t  q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbd_pkg::run_desc_t  out_data_o
);

  logic               valid_q;
  pbd_pkg::run_desc_t data_q;

  // refill whenever the register is empty or being taken this cycle
  assign q_pop_o     = q_nonempty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) data_q <= q_data_i;
  end

endmodule
